>>> rtl/rbge_pkg.sv
// Shared types, register codes, reset values and fixed-point helpers of the body step block.
`default_nettype none

package rbge_pkg;

  // Configuration port geometry: five 32-bit registers at byte addresses 4*i.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF    = 3'd4;

  // Reset values of the registers.
  localparam logic signed [31:0] GRAVITY_RST = -32'sd642253;
  localparam logic signed [31:0] GROUND_RST  = -32'sd131072;
  localparam logic [16:0]        BOUNCE_RST  = 17'd6554;
  localparam logic [16:0]        STEP_RST    = 17'd1092;
  localparam logic [22:0]        HALF_RST    = 23'd32768;

  // Saturation limits of a signed Q16.16 word.
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Register set as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] gravity_y;
    logic signed [31:0] ground_level;
    logic [16:0]        bounce_factor;
    logic [16:0]        step_interval;
    logic [22:0]        half_extent;
  } cfg_t;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? S32_MIN : S32_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Saturating add of two signed Q16.16 words.
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat32(s);
  endfunction

  // Signed 33 by 33 bit product, exact.
  function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    return p;
  endfunction

  // Round a Q32.32 product to Q16.16 (half up) and saturate to 32 bits.
  function automatic logic signed [31:0] qround_sat(input logic signed [65:0] p);
    logic signed [65:0] x;
    logic signed [31:0] r;
    x = p + 66'sd32768;
    if ((&x[65:47]) || !(|x[65:47])) begin
      r = x[47:16];
    end else begin
      r = x[65] ? S32_MIN : S32_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rbge_if.sv
// Valid/ready channel interfaces for body beats and result beats.
`default_nettype none

interface rbge_body_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [31:0]        body_mass;
  logic [31:0]        inv_mass;
  logic               is_fixed;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  body_mass, inv_mass, is_fixed, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  body_mass, inv_mass, is_fixed, output ready);
endinterface

interface rbge_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic               hit_ground;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, hit_ground, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, hit_ground, output ready);
endinterface

`default_nettype wire

>>> rtl/rbge_cfg.sv
// APB register file holding gravity, floor, restitution, time step and half extent.
`default_nettype none

module rbge_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbge_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output rbge_pkg::cfg_t                     cfg_o
);

  rbge_pkg::cfg_t                  cfg_d, cfg_q;
  logic [rbge_pkg::CFG_IDX_W-1:0]  idx;
  logic                            wr;

  assign pready = 1'b1;
  assign idx    = paddr[rbge_pkg::CFG_ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  // Write decode: unknown indexes leave every register alone.
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        rbge_pkg::REG_GRAVITY: cfg_d.gravity_y     = pwdata;
        rbge_pkg::REG_GROUND:  cfg_d.ground_level  = pwdata;
        rbge_pkg::REG_BOUNCE:  cfg_d.bounce_factor = pwdata[16:0];
        rbge_pkg::REG_STEP:    cfg_d.step_interval = pwdata[16:0];
        rbge_pkg::REG_HALF:    cfg_d.half_extent   = pwdata[22:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_y     <= rbge_pkg::GRAVITY_RST;
      cfg_q.ground_level  <= rbge_pkg::GROUND_RST;
      cfg_q.bounce_factor <= rbge_pkg::BOUNCE_RST;
      cfg_q.step_interval <= rbge_pkg::STEP_RST;
      cfg_q.half_extent   <= rbge_pkg::HALF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux, values zero-extended to the bus width.
  always_comb begin
    case (idx)
      rbge_pkg::REG_GRAVITY: prdata = cfg_q.gravity_y;
      rbge_pkg::REG_GROUND:  prdata = cfg_q.ground_level;
      rbge_pkg::REG_BOUNCE:  prdata = {15'd0, cfg_q.bounce_factor};
      rbge_pkg::REG_STEP:    prdata = {15'd0, cfg_q.step_interval};
      rbge_pkg::REG_HALF:    prdata = {9'd0, cfg_q.half_extent};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/rbge_pipe.sv
// Eight-stage datapath: floor contact, gravity chain and position update per body.
`default_nettype none

module rbge_pipe (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rbge_pkg::cfg_t cfg_i,
  rbge_body_if.sink           body_i,
  rbge_result_if.source       result_o
);

  localparam int NSTG = 8;

  // Body state that travels down the whole pipe.
  typedef struct packed {
    logic               fixed;
    logic               hit;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } carry_t;

  typedef struct packed {
    carry_t             c;
    logic               bsel;
    logic [31:0]        inv;
    logic signed [65:0] prod_b;
    logic signed [65:0] prod_f;
    logic signed [65:0] prod_x;
    logic signed [65:0] prod_z;
  } st1_t;

  typedef struct packed {
    carry_t             c;
    logic [31:0]        inv;
    logic signed [31:0] force_q;
    logic signed [31:0] dpx;
    logic signed [31:0] dpz;
  } st2_t;

  typedef struct packed {
    carry_t             c;
    logic signed [65:0] w;
  } stw_t;

  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;

  st1_t   s1_d, s1_q;
  st2_t   s2_d, s2_q;
  stw_t   s3_d, s3_q, s4_d, s4_q, s5_d, s5_q, s7_d, s7_q;
  carry_t s6_d, s6_q, s8_d, s8_q;

  logic signed [32:0] bottom;
  logic signed [32:0] clamp_sum;
  logic               below;
  logic signed [32:0] step_s;
  logic signed [31:0] dv;

  // Ready ripples back: a stage takes a beat when it is empty or its successor takes.
  always_comb begin
    rdy[NSTG] = result_o.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign body_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= body_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign step_s = {16'd0, cfg_i.step_interval};

  // Stage 1: floor test and clamp, first products.
  always_comb begin
    bottom    = {body_i.pos_y[31], body_i.pos_y} - {10'd0, cfg_i.half_extent};
    below     = bottom < $signed({cfg_i.ground_level[31], cfg_i.ground_level});
    clamp_sum = {cfg_i.ground_level[31], cfg_i.ground_level} + {10'd0, cfg_i.half_extent};

    s1_d.c.fixed = body_i.is_fixed;
    s1_d.c.hit   = !body_i.is_fixed && below;
    s1_d.c.px    = body_i.pos_x;
    s1_d.c.py    = s1_d.c.hit ? rbge_pkg::sat32(clamp_sum) : body_i.pos_y;
    s1_d.c.pz    = body_i.pos_z;
    s1_d.c.vx    = body_i.vel_x;
    s1_d.c.vy    = body_i.vel_y;
    s1_d.c.vz    = body_i.vel_z;
    s1_d.bsel    = s1_d.c.hit && body_i.vel_y[31];
    s1_d.inv     = body_i.inv_mass;
    s1_d.prod_b  = rbge_pkg::mul33(-{body_i.vel_y[31], body_i.vel_y},
                                   {16'd0, cfg_i.bounce_factor});
    s1_d.prod_f  = rbge_pkg::mul33({cfg_i.gravity_y[31], cfg_i.gravity_y},
                                   {1'b0, body_i.body_mass});
    s1_d.prod_x  = rbge_pkg::mul33({body_i.vel_x[31], body_i.vel_x}, step_s);
    s1_d.prod_z  = rbge_pkg::mul33({body_i.vel_z[31], body_i.vel_z}, step_s);
  end

  // Stage 2: round the first products, apply the bounce.
  always_comb begin
    s2_d.c       = s1_q.c;
    s2_d.c.vy    = s1_q.bsel ? rbge_pkg::qround_sat(s1_q.prod_b) : s1_q.c.vy;
    s2_d.inv     = s1_q.inv;
    s2_d.force_q = rbge_pkg::qround_sat(s1_q.prod_f);
    s2_d.dpx     = rbge_pkg::qround_sat(s1_q.prod_x);
    s2_d.dpz     = rbge_pkg::qround_sat(s1_q.prod_z);
  end

  // Stage 3: force times inverse mass; x and z positions finish here.
  always_comb begin
    s3_d.c    = s2_q.c;
    s3_d.c.px = s2_q.c.fixed ? s2_q.c.px : rbge_pkg::add_sat(s2_q.c.px, s2_q.dpx);
    s3_d.c.pz = s2_q.c.fixed ? s2_q.c.pz : rbge_pkg::add_sat(s2_q.c.pz, s2_q.dpz);
    s3_d.w    = rbge_pkg::mul33({s2_q.force_q[31], s2_q.force_q}, {1'b0, s2_q.inv});
  end

  // Stage 4: round the acceleration.
  always_comb begin
    s4_d.c = s3_q.c;
    s4_d.w = 66'(rbge_pkg::qround_sat(s3_q.w));
  end

  // Stage 5: acceleration times time step.
  always_comb begin
    s5_d.c = s4_q.c;
    s5_d.w = rbge_pkg::mul33(s4_q.w[32:0], step_s);
  end

  // Stage 6: round the velocity change and add it to y velocity.
  always_comb begin
    dv      = rbge_pkg::qround_sat(s5_q.w);
    s6_d    = s5_q.c;
    s6_d.vy = s5_q.c.fixed ? s5_q.c.vy : rbge_pkg::add_sat(s5_q.c.vy, dv);
  end

  // Stage 7: new y velocity times time step.
  always_comb begin
    s7_d.c = s6_q;
    s7_d.w = rbge_pkg::mul33({s6_q.vy[31], s6_q.vy}, step_s);
  end

  // Stage 8: y position update into the output register.
  always_comb begin
    s8_d    = s7_q.c;
    s8_d.py = s7_q.c.fixed ? s7_q.c.py
                           : rbge_pkg::add_sat(s7_q.c.py, rbge_pkg::qround_sat(s7_q.w));
  end

  // Payload registers load whenever their stage takes a beat.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_q <= s1_d;
    end
    if (rdy[1]) begin
      s2_q <= s2_d;
    end
    if (rdy[2]) begin
      s3_q <= s3_d;
    end
    if (rdy[3]) begin
      s4_q <= s4_d;
    end
    if (rdy[4]) begin
      s5_q <= s5_d;
    end
    if (rdy[5]) begin
      s6_q <= s6_d;
    end
    if (rdy[6]) begin
      s7_q <= s7_d;
    end
    if (rdy[7]) begin
      s8_q <= s8_d;
    end
  end

  // Result beat.
  assign result_o.valid      = v_q[NSTG-1];
  assign result_o.new_pos_x  = s8_q.px;
  assign result_o.new_pos_y  = s8_q.py;
  assign result_o.new_pos_z  = s8_q.pz;
  assign result_o.new_vel_x  = s8_q.vx;
  assign result_o.new_vel_y  = s8_q.vy;
  assign result_o.new_vel_z  = s8_q.vz;
  assign result_o.hit_ground = s8_q.hit;

endmodule

`default_nettype wire

>>> rtl/rigid_body_ground_euler_step.sv
// Top level of the rigid body floor contact and semi-implicit Euler step block.
//
//   Channel   Direction  Handshake             Beat
//   body_i    in         valid/ready           one body: position, velocity, masses, flag
//   result_o  out        valid/ready           updated position, velocity, contact flag
//   APB       in/out     psel/penable/pready   one 32-bit register write or read
//
// One body enters per cycle while body_i.ready is high; each accepted beat passes through
// four multiply stages, each followed by a rounding and saturation stage.
// Reset clears the stage valid bits and loads the register defaults.
// Ready ripples back stage by stage, so empty stages keep filling while a result waits.
`default_nettype none

module rigid_body_ground_euler_step (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rbge_body_if.sink                            body_i,
  rbge_result_if.source                        result_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rbge_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  rbge_pkg::cfg_t cfg;
  logic           cfg_wr;

  rbge_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbge_pipe u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .body_i   (body_i),
    .result_o (result_o)
  );

  assign cfg_wr = psel && penable && pwrite && pready;

  // The input only stalls when every stage is full and the output is held.
  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !body_i.ready |-> (result_o.valid && !result_o.ready))
    else $error("input stalled while the pipe still had room");

  // A restitution write shows in the register in the cycle after the write.
  a_bounce_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[rbge_pkg::CFG_ADDR_W-1:2] == rbge_pkg::REG_BOUNCE)
    |=> (cfg.bounce_factor == $past(pwdata[16:0])))
    else $error("restitution register did not take the written value");

  // A write to an index outside the register list changes nothing.
  a_unknown_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[rbge_pkg::CFG_ADDR_W-1:2] != rbge_pkg::REG_GRAVITY
            && paddr[rbge_pkg::CFG_ADDR_W-1:2] != rbge_pkg::REG_GROUND
            && paddr[rbge_pkg::CFG_ADDR_W-1:2] != rbge_pkg::REG_BOUNCE
            && paddr[rbge_pkg::CFG_ADDR_W-1:2] != rbge_pkg::REG_STEP
            && paddr[rbge_pkg::CFG_ADDR_W-1:2] != rbge_pkg::REG_HALF)
    |=> $stable(cfg))
    else $error("write to an unlisted index altered the registers");

endmodule

`default_nettype wire

>>> tb/tb_rigid_body_ground_euler_step.sv
// Self-checking testbench of the rigid body floor contact and Euler step block.
`timescale 1ns / 1ps

module tb_rigid_body_ground_euler_step;

  localparam int PIPE_LATENCY   = 8;
  localparam int DRAIN_CYCLES   = 4 * PIPE_LATENCY;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_REGS       = 5;
  localparam int MAX_REPORTS    = 10;

  // One body as it travels on the input channel.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        body_mass;
    logic [31:0]        inv_mass;
    logic               is_fixed;
  } body_t;

  // One updated body as it leaves on the result channel.
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               hit_ground;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [rbge_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  rbge_body_if   body_if ();
  rbge_result_if result_if ();

  rigid_body_ground_euler_step u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .body_i   (body_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Local copy of the register set, as the block should hold it.
  logic signed [31:0] cfg_gravity = rbge_pkg::GRAVITY_RST;
  logic signed [31:0] cfg_ground  = rbge_pkg::GROUND_RST;
  logic [16:0]        cfg_bounce  = rbge_pkg::BOUNCE_RST;
  logic [16:0]        cfg_step    = rbge_pkg::STEP_RST;
  logic [22:0]        cfg_half    = rbge_pkg::HALF_RST;

  result_t predicted_bodies[$];
  int      mismatch_count = 0;
  int      results_seen   = 0;
  int      idle_cycles    = 0;
  bit      calm_mode      = 1'b0;

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round a Q32.32 product to Q16.16, ties upwards.
  function automatic longint round_q16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    return clamp_s32(round_q16(a * b));
  endfunction

  // Height at which a body rests on the floor, before saturation.
  function automatic longint floor_top();
    return longint'(cfg_ground) + longint'(cfg_half);
  endfunction

  function automatic result_t predict_euler_step(body_t b);
    result_t r;
    longint  py, vy, dv, dt;
    dt = cfg_step;
    py = b.pos_y;
    vy = b.vel_y;
    r.new_pos_x  = b.pos_x;
    r.new_pos_y  = b.pos_y;
    r.new_pos_z  = b.pos_z;
    r.new_vel_x  = b.vel_x;
    r.new_vel_y  = b.vel_y;
    r.new_vel_z  = b.vel_z;
    r.hit_ground = 1'b0;
    if (!b.is_fixed) begin
      // Floor contact: clamp the height, reflect a downward velocity.
      if (py - longint'(cfg_half) < longint'(cfg_ground)) begin
        r.hit_ground = 1'b1;
        py = clamp_s32(floor_top());
        if (vy < 0) begin
          vy = clamp_s32(round_q16(-vy * longint'(cfg_bounce)));
        end
      end
      // Gravity first, then position from the new velocity.
      dv = mul_q16(mul_q16(mul_q16(cfg_gravity, b.body_mass), b.inv_mass), dt);
      vy = clamp_s32(vy + dv);
      r.new_vel_y = 32'(vy);
      r.new_pos_x = 32'(clamp_s32(longint'(b.pos_x) + mul_q16(b.vel_x, dt)));
      r.new_pos_y = 32'(clamp_s32(py + mul_q16(vy, dt)));
      r.new_pos_z = 32'(clamp_s32(longint'(b.pos_z) + mul_q16(b.vel_z, dt)));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned roll;
    if (calm_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int near_zero(int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  function automatic body_t make_body(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                      logic [31:0] mass, logic [31:0] inv, logic fixed);
    body_t b;
    b.pos_x     = px;
    b.pos_y     = py;
    b.pos_z     = pz;
    b.vel_x     = vx;
    b.vel_y     = vy;
    b.vel_z     = vz;
    b.body_mass = mass;
    b.inv_mass  = inv;
    b.is_fixed  = fixed;
    return b;
  endfunction

  // Mostly plausible bodies near the floor, the rest raw noise.
  function automatic body_t random_body();
    body_t       b;
    longint      offset;
    logic [31:0] mass;
    if ($urandom_range(0, 99) < 25) begin
      b = make_body($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      case ($urandom_range(0, 3))
        0:       offset = 0;
        1:       offset = -1;
        2:       offset = near_zero(1 << 16);
        default: offset = near_zero(4 << 16);
      endcase
      mass = $urandom_range(1 << 12, 16 << 16);
      b = make_body(near_zero(10 << 16), 32'(floor_top() + offset), near_zero(10 << 16),
                    near_zero(20 << 16), near_zero(20 << 16), near_zero(20 << 16),
                    mass, 32'((64'd1 << 32) / mass), $urandom_range(0, 7) == 0);
    end
    return b;
  endfunction

  // Present one body, hold it until accepted, record its expected update.
  task automatic send_body(input body_t b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      body_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_if.valid     <= 1'b1;
    body_if.pos_x     <= b.pos_x;
    body_if.pos_y     <= b.pos_y;
    body_if.pos_z     <= b.pos_z;
    body_if.vel_x     <= b.vel_x;
    body_if.vel_y     <= b.vel_y;
    body_if.vel_z     <= b.vel_z;
    body_if.body_mass <= b.body_mass;
    body_if.inv_mass  <= b.inv_mass;
    body_if.is_fixed  <= b.is_fixed;
    do @(posedge clk); while (!body_if.ready);
    predicted_bodies.insert(predicted_bodies.size(), predict_euler_step(b));
  endtask

  task automatic send_random_bodies(input int count);
    repeat (count) send_body(random_body());
  endtask

  // Drop valid and let the pipeline empty before touching a register.
  task automatic wait_idle();
    @(negedge clk);
    body_if.valid <= 1'b0;
    while (predicted_bodies.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic apb_write(input logic [rbge_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      rbge_pkg::REG_GRAVITY: cfg_gravity = data;
      rbge_pkg::REG_GROUND:  cfg_ground  = data;
      rbge_pkg::REG_BOUNCE:  cfg_bounce  = data[16:0];
      rbge_pkg::REG_STEP:    cfg_step    = data[16:0];
      rbge_pkg::REG_HALF:    cfg_half    = data[22:0];
      default:               ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] gravity, input logic [31:0] ground,
                            input logic [31:0] bounce, input logic [31:0] dt,
                            input logic [31:0] half);
    wait_idle();
    apb_write(rbge_pkg::REG_GRAVITY, gravity);
    apb_write(rbge_pkg::REG_GROUND, ground);
    apb_write(rbge_pkg::REG_BOUNCE, bounce);
    apb_write(rbge_pkg::REG_STEP, dt);
    apb_write(rbge_pkg::REG_HALF, half);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the contact corner cases, with the reset register values.
  task automatic test_directed_defaults();
    logic [31:0] rest_y;
    logic [31:0] one;
    rest_y = 32'(floor_top());
    one    = 32'h0001_0000;
    // Static bodies pass through, even below the floor.
    send_body(make_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, '1, '1, 1'b1));
    send_body(make_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 1'b1));
    send_body(make_body('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    send_body(make_body('0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    // Free fall well above the floor.
    send_body(make_body(one, one, one, '0, '0, '0, one, one, 1'b0));
    // Bottom exactly on the floor is not a contact.
    send_body(make_body('0, rest_y, '0, '0, -one, '0, one, one, 1'b0));
    // Just below: contact with downward, zero and upward vertical velocity.
    send_body(make_body('0, rest_y - 1, '0, '0, -2 * one, '0, one, one, 1'b0));
    send_body(make_body('0, rest_y - 1, '0, '0, '0, '0, one, one, 1'b0));
    send_body(make_body('0, rest_y - 1, '0, '0, 3 * one, '0, one, one, 1'b0));
    send_body(make_body('0, rest_y - 1, '0, '0, 32'h8000_0000, '0, one, one, 1'b0));
    send_body(make_body('0, 32'h8000_0000, '0, one, 32'h8000_0001, -one, one, one, 1'b0));
    // Position saturation in both directions.
    send_body(make_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, one, one, 1'b0));
    send_body(make_body(32'h8000_0000, 32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0000, 32'h7FFF_FFFF, one, one, 1'b0));
    // Mass extremes: saturated force and acceleration, and zero terms.
    send_body(make_body('0, one, '0, '0, '0, '0, '1, '1, 1'b0));
    send_body(make_body('0, one, '0, '0, '0, '0, '0, '1, 1'b0));
    send_body(make_body('0, one, '0, '0, '0, '0, '1, '0, 1'b0));
    send_body(make_body('0, one, '0, '0, 32'h8000_0000, '0, '1, '1, 1'b0));
    // Rounding of tiny velocities.
    send_body(make_body(one, one, one, 32'd1, 32'd30, -32'd30, 32'd1, 32'd1, 1'b0));
    send_body(make_body(-one, one, -one, -32'd1, -32'd31, 32'd31, 32'd2, 32'd3, 1'b0));
  endtask

  // Register extremes, each followed by a batch of bodies.
  task automatic test_register_extremes();
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'd65536, 32'd4194304);
    send_random_bodies(30);
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_random_bodies(30);
    // Floor plus half extent saturates; restitution and step above one.
    set_config(32'h0000_0001, 32'h7FF0_0000, 32'h0001_FFFF, 32'h0001_FFFF, 32'h007F_FFFF);
    send_random_bodies(30);
    // Bits above each register's width are dropped.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random_bodies(30);
  endtask

  // Writes to addresses with no register must change nothing.
  task automatic test_unknown_register();
    set_config(rbge_pkg::GRAVITY_RST, rbge_pkg::GROUND_RST, rbge_pkg::BOUNCE_RST,
               rbge_pkg::STEP_RST, rbge_pkg::HALF_RST);
    for (int i = NUM_REGS; i < (1 << rbge_pkg::CFG_IDX_W); i++) begin
      apb_write(i[rbge_pkg::CFG_IDX_W-1:0], $urandom);
    end
    send_random_bodies(20);
  endtask

  // Random register settings, mostly physical, with one phase free of idling.
  task automatic test_random_settings();
    logic [31:0] gravity, ground, bounce, dt, half;
    for (int phase = 0; phase < 6; phase++) begin
      gravity = ($urandom_range(0, 3) == 0) ? $urandom : 32'(near_zero(20 << 16));
      ground  = ($urandom_range(0, 3) == 0) ? $urandom : 32'(near_zero(10 << 16));
      bounce  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 65536);
      dt      = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 65536);
      half    = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 4194304);
      set_config(gravity, ground, bounce, dt, half);
      calm_mode = (phase == 3);
      send_random_bodies(150);
    end
    calm_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stalls, checking and watchdog
  // ---------------------------------------------------------------------------

  initial begin : result_ready_drive
    int gap;
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        gap = pick_gap();
        result_if.ready <= (gap == 0);
        stall_left = (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      got = '{result_if.new_pos_x, result_if.new_pos_y, result_if.new_pos_z,
              result_if.new_vel_x, result_if.new_vel_y, result_if.new_vel_z,
              result_if.hit_ground};
      if (predicted_bodies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result beat %0d arrived with no body outstanding", results_seen);
        end
      end else begin
        want = predicted_bodies.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result beat %0d mismatch", results_seen);
            $display("  expected pos %h %h %h vel %h %h %h hit %b",
                     want.new_pos_x, want.new_pos_y, want.new_pos_z,
                     want.new_vel_x, want.new_vel_y, want.new_vel_z, want.hit_ground);
            $display("  actual   pos %h %h %h vel %h %h %h hit %b",
                     got.new_pos_x, got.new_pos_y, got.new_pos_z,
                     got.new_vel_x, got.new_vel_y, got.new_vel_z, got.hit_ground);
          end
        end
      end
      results_seen++;
    end
  end

  // End the run if neither channel moves a beat for too long.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((body_if.valid && body_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_rigid_body_ground_euler_step: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    body_if.valid     = 1'b0;
    body_if.pos_x     = '0;
    body_if.pos_y     = '0;
    body_if.pos_z     = '0;
    body_if.vel_x     = '0;
    body_if.vel_y     = '0;
    body_if.vel_z     = '0;
    body_if.body_mass = '0;
    body_if.inv_mass  = '0;
    body_if.is_fixed  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_unknown_register();
    test_random_settings();

    // Drain, then allow stray beats a chance to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_bodies.size() == 0) begin
      $display("tb_rigid_body_ground_euler_step: PASS");
    end else begin
      $display("tb_rigid_body_ground_euler_step: FAIL");
    end
    $finish;
  end

endmodule
